/* design/line_edit_buffer_macros.svh */
// Assertion macros for the line edit buffer datapath.
`ifndef LINE_EDIT_BUFFER_MACROS_SVH
`define LINE_EDIT_BUFFER_MACROS_SVH
`ifndef SYNTH
// Checks a property at every rising clock edge outside reset.
`define LEB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Checks that a condition holds in the clock cycle after its trigger.
`define LEB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LEB_ASSERT(lbl, prop, msg)
`define LEB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/leb_pkg.sv */
// Shared types, constants and helpers for the line edit buffer.
package leb_pkg;

    localparam int BUF_DEPTH  = 64;
    localparam int MAX_LINE   = BUF_DEPTH - 2;
    localparam int ADDR_W     = $clog2(BUF_DEPTH);
    localparam int POS_W      = 6;
    localparam int CHAR_W     = 8;
    localparam int TICK_W     = 16;
    localparam int MAX_SIZE_W = 7;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;

    typedef logic [POS_W-1:0]      t_pos;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CHAR_W-1:0]     t_char;
    typedef logic [TICK_W-1:0]     t_tick;
    typedef logic [MAX_SIZE_W-1:0] t_max_size;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [1:0]            t_status;

    // Fixed key codes.
    localparam t_char KEY_BS  = 8'd8;
    localparam t_char KEY_DEL = 8'd127;
    localparam t_char KEY_LF  = 8'd10;
    localparam t_char KEY_CR  = 8'd13;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_MAX_SIZE  = 3'd0;
    localparam t_cfg_idx CFG_TIMEOUT   = 3'd1;
    localparam t_cfg_idx CFG_KEY_LEFT  = 3'd2;
    localparam t_cfg_idx CFG_KEY_RIGHT = 3'd3;
    localparam t_cfg_idx CFG_KEY_BREAK = 3'd4;

    // Result status codes.
    localparam t_status ST_HANDLED = 2'd0;
    localparam t_status ST_CHAR    = 2'd1;
    localparam t_status ST_BREAK   = 2'd2;
    localparam t_status ST_TIMEOUT = 2'd3;

    localparam logic MODE_TICK = 1'b1;

    // What the latched word asks for.
    typedef enum logic [3:0] {
        C_TICK_IGNORE, C_TICK_COUNT, C_TIMEOUT, C_ENTER, C_BREAK,
        C_LEFT, C_RIGHT, C_ERASE, C_INSERT
    } t_cls;

    // Change to cursor, length or tick count for the datapath to apply.
    typedef enum logic [2:0] {
        E_NONE, E_CLEAR, E_LEFT, E_RIGHT, E_ERASE, E_INSERT, E_TICK
    } t_edit;

    // Kind of result loaded into the output register.
    typedef enum logic [2:0] {
        K_HANDLED, K_EMPTY, K_CHAR, K_BREAK, K_TIMEOUT
    } t_kind;

    // Scan pointer operations.
    typedef enum logic [2:0] {
        P_HOLD, P_ZERO, P_CURSOR, P_LAST, P_INC, P_DEC
    } t_pop;

    // Store write address selection.
    typedef enum logic [1:0] {
        W_DOWN, W_UP, W_CURSOR
    } t_wsel;

    typedef struct packed {
        logic  latch;
        t_pop  ptr_op;
        logic  wr_en;
        t_wsel wr_sel;
        t_edit edit;
        logic  out_load;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic cur_zero;
        logic cur_at_end;
        logic ptr_at_cursor;
        logic ptr_last;
        logic len_zero;
        logic has_room;
        logic out_free;
    } t_sts;

    // Number of characters the line may hold for a given buffer size.
    function automatic t_pos capacity(input t_max_size max_size);
        if (32'(max_size) >= BUF_DEPTH) begin
            return t_pos'(MAX_LINE);
        end else if (max_size < t_max_size'(2)) begin
            return '0;
        end else begin
            return t_pos'(max_size - t_max_size'(2));
        end
    endfunction

endpackage

/* design/leb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module leb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when the same entry is written.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/leb_ctrl.sv */
// Control state machine of the line edit buffer.
module leb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  leb_pkg::t_sts i_sts,
    output leb_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_ERASE, S_INSERT, S_DUMP, S_REPLY
    } t_state;

    t_state         r_state, n_state;
    leb_pkg::t_kind r_kind, n_kind;
    leb_pkg::t_edit r_edit, n_edit;
    leb_pkg::t_cmd  n_cmd;

    always_comb begin
        n_state        = r_state;
        n_kind         = r_kind;
        n_edit         = r_edit;
        n_cmd.latch    = 1'b0;
        n_cmd.ptr_op   = leb_pkg::P_HOLD;
        n_cmd.wr_en    = 1'b0;
        n_cmd.wr_sel   = leb_pkg::W_DOWN;
        n_cmd.edit     = leb_pkg::E_NONE;
        n_cmd.out_load = 1'b0;
        n_cmd.kind     = leb_pkg::K_HANDLED;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_kind  = leb_pkg::K_HANDLED;
                n_edit  = leb_pkg::E_NONE;
                n_state = S_REPLY;
                case (i_sts.cls)
                    leb_pkg::C_TICK_IGNORE: n_state = S_IDLE;
                    leb_pkg::C_TICK_COUNT: begin
                        n_cmd.edit = leb_pkg::E_TICK;
                        n_state    = S_IDLE;
                    end
                    leb_pkg::C_TIMEOUT: begin
                        n_kind = leb_pkg::K_TIMEOUT;
                        n_edit = leb_pkg::E_CLEAR;
                    end
                    leb_pkg::C_BREAK: begin
                        n_kind = leb_pkg::K_BREAK;
                        n_edit = leb_pkg::E_CLEAR;
                    end
                    leb_pkg::C_LEFT:  n_edit = leb_pkg::E_LEFT;
                    leb_pkg::C_RIGHT: n_edit = leb_pkg::E_RIGHT;
                    leb_pkg::C_ERASE: begin
                        if (!i_sts.cur_zero) begin
                            n_edit = leb_pkg::E_ERASE;
                            if (!i_sts.cur_at_end) begin
                                n_cmd.ptr_op = leb_pkg::P_CURSOR;
                                n_state      = S_ERASE;
                            end
                        end
                    end
                    leb_pkg::C_INSERT: begin
                        if (i_sts.has_room) begin
                            n_edit = leb_pkg::E_INSERT;
                            if (!i_sts.cur_at_end) begin
                                n_cmd.ptr_op = leb_pkg::P_LAST;
                                n_state      = S_INSERT;
                            end
                        end
                    end
                    leb_pkg::C_ENTER: begin
                        if (i_sts.len_zero) begin
                            n_kind = leb_pkg::K_EMPTY;
                            n_edit = leb_pkg::E_CLEAR;
                        end else begin
                            n_cmd.ptr_op = leb_pkg::P_ZERO;
                            n_state      = S_DUMP;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_ERASE: begin
                // Move the tail one place toward the cursor.
                n_cmd.wr_en  = 1'b1;
                n_cmd.wr_sel = leb_pkg::W_DOWN;
                if (i_sts.ptr_last) begin
                    n_state = S_REPLY;
                end else begin
                    n_cmd.ptr_op = leb_pkg::P_INC;
                end
            end
            S_INSERT: begin
                // Move the tail one place away from the cursor, last first.
                n_cmd.wr_en  = 1'b1;
                n_cmd.wr_sel = leb_pkg::W_UP;
                if (i_sts.ptr_at_cursor) begin
                    n_state = S_REPLY;
                end else begin
                    n_cmd.ptr_op = leb_pkg::P_DEC;
                end
            end
            S_DUMP: begin
                if (i_sts.out_free) begin
                    n_cmd.out_load = 1'b1;
                    n_cmd.kind     = leb_pkg::K_CHAR;
                    if (i_sts.ptr_last) begin
                        n_cmd.edit = leb_pkg::E_CLEAR;
                        n_state    = S_IDLE;
                    end else begin
                        n_cmd.ptr_op = leb_pkg::P_INC;
                    end
                end
            end
            S_REPLY: begin
                if (i_sts.out_free) begin
                    n_cmd.out_load = 1'b1;
                    n_cmd.kind     = r_kind;
                    n_cmd.edit     = r_edit;
                    if (r_edit == leb_pkg::E_INSERT) begin
                        n_cmd.wr_en  = 1'b1;
                        n_cmd.wr_sel = leb_pkg::W_CURSOR;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= leb_pkg::K_HANDLED;
            r_edit  <= leb_pkg::E_NONE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_edit  <= n_edit;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = n_cmd;

endmodule

/* design/leb_dp.sv */
// Datapath of the line edit buffer: settings, line state, store and result register.
`include "line_edit_buffer_macros.svh"
module leb_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_mode,
    input  leb_pkg::t_char           i_key,
    input  logic                     i_cfg_we,
    input  leb_pkg::t_cfg_idx        i_cfg_index,
    input  logic [leb_pkg::CFG_W-1:0] i_cfg_data,
    input  leb_pkg::t_cmd            i_cmd,
    output leb_pkg::t_sts            o_sts,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output leb_pkg::t_status         o_status,
    output leb_pkg::t_char           o_char_out,
    output leb_pkg::t_pos            o_cursor_pos,
    output leb_pkg::t_pos            o_line_length,
    output logic                     o_last
);

    leb_pkg::t_max_size r_max_size;
    leb_pkg::t_tick     r_timeout;
    leb_pkg::t_char     r_key_left, r_key_right, r_key_break;

    logic               r_mode;
    leb_pkg::t_char     r_key;

    leb_pkg::t_pos      r_cursor, n_cursor;
    leb_pkg::t_pos      r_len, n_len;
    leb_pkg::t_tick     r_tick, n_tick, tick_inc;
    leb_pkg::t_pos      r_ptr, n_ptr;
    leb_pkg::t_pos      len_m1;

    leb_pkg::t_addr     ram_waddr;
    leb_pkg::t_char     ram_wdata, ram_rdata;

    logic               r_out_valid;
    leb_pkg::t_status   r_status, n_status;
    leb_pkg::t_char     r_char, n_char;
    leb_pkg::t_pos      r_out_cursor, n_out_cursor;
    leb_pkg::t_pos      r_out_len, n_out_len;
    logic               r_last, n_last;
    logic               out_free;
    leb_pkg::t_cls      cls;

    // Settings.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size  <= leb_pkg::t_max_size'(64);
            r_timeout   <= '0;
            r_key_left  <= leb_pkg::t_char'(28);
            r_key_right <= leb_pkg::t_char'(29);
            r_key_break <= leb_pkg::t_char'(3);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                leb_pkg::CFG_MAX_SIZE:  r_max_size  <= i_cfg_data[leb_pkg::MAX_SIZE_W-1:0];
                leb_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_data[leb_pkg::TICK_W-1:0];
                leb_pkg::CFG_KEY_LEFT:  r_key_left  <= i_cfg_data[leb_pkg::CHAR_W-1:0];
                leb_pkg::CFG_KEY_RIGHT: r_key_right <= i_cfg_data[leb_pkg::CHAR_W-1:0];
                leb_pkg::CFG_KEY_BREAK: r_key_break <= i_cfg_data[leb_pkg::CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    // Word latched at accept.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_mode;
            r_key  <= i_key;
        end
    end

    assign tick_inc = (r_tick == '1) ? r_tick : r_tick + leb_pkg::t_tick'(1);
    assign len_m1   = r_len - leb_pkg::t_pos'(1);

    // Classification in priority order.
    always_comb begin
        if (r_mode == leb_pkg::MODE_TICK) begin
            if (r_timeout == '0) begin
                cls = leb_pkg::C_TICK_IGNORE;
            end else if (tick_inc >= r_timeout) begin
                cls = leb_pkg::C_TIMEOUT;
            end else begin
                cls = leb_pkg::C_TICK_COUNT;
            end
        end else if (r_key == leb_pkg::KEY_LF || r_key == leb_pkg::KEY_CR) begin
            cls = leb_pkg::C_ENTER;
        end else if (r_key == r_key_break) begin
            cls = leb_pkg::C_BREAK;
        end else if (r_key == r_key_left) begin
            cls = leb_pkg::C_LEFT;
        end else if (r_key == r_key_right) begin
            cls = leb_pkg::C_RIGHT;
        end else if (r_key == leb_pkg::KEY_BS || r_key == leb_pkg::KEY_DEL) begin
            cls = leb_pkg::C_ERASE;
        end else begin
            cls = leb_pkg::C_INSERT;
        end
    end

    // Cursor, length and tick count updates.
    always_comb begin
        n_cursor = r_cursor;
        n_len    = r_len;
        n_tick   = r_tick;
        case (i_cmd.edit)
            leb_pkg::E_CLEAR: begin
                n_cursor = '0;
                n_len    = '0;
                n_tick   = '0;
            end
            leb_pkg::E_LEFT: begin
                if (r_cursor != '0) n_cursor = r_cursor - leb_pkg::t_pos'(1);
            end
            leb_pkg::E_RIGHT: begin
                if (r_cursor < r_len) n_cursor = r_cursor + leb_pkg::t_pos'(1);
            end
            leb_pkg::E_ERASE: begin
                n_cursor = r_cursor - leb_pkg::t_pos'(1);
                n_len    = len_m1;
            end
            leb_pkg::E_INSERT: begin
                n_cursor = r_cursor + leb_pkg::t_pos'(1);
                n_len    = r_len + leb_pkg::t_pos'(1);
            end
            leb_pkg::E_TICK: n_tick = tick_inc;
            default: ;
        endcase
    end

    always_comb begin
        case (i_cmd.ptr_op)
            leb_pkg::P_ZERO:   n_ptr = '0;
            leb_pkg::P_CURSOR: n_ptr = r_cursor;
            leb_pkg::P_LAST:   n_ptr = len_m1;
            leb_pkg::P_INC:    n_ptr = r_ptr + leb_pkg::t_pos'(1);
            leb_pkg::P_DEC:    n_ptr = r_ptr - leb_pkg::t_pos'(1);
            default:           n_ptr = r_ptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_len    <= '0;
            r_tick   <= '0;
            r_ptr    <= '0;
        end else begin
            r_cursor <= n_cursor;
            r_len    <= n_len;
            r_tick   <= n_tick;
            r_ptr    <= n_ptr;
        end
    end

    // The store is read at the next pointer, so its data always matches r_ptr.
    always_comb begin
        case (i_cmd.wr_sel)
            leb_pkg::W_DOWN: ram_waddr = leb_pkg::t_addr'(r_ptr - leb_pkg::t_pos'(1));
            leb_pkg::W_UP:   ram_waddr = leb_pkg::t_addr'(r_ptr + leb_pkg::t_pos'(1));
            default:         ram_waddr = leb_pkg::t_addr'(r_cursor);
        endcase
        ram_wdata = (i_cmd.wr_sel == leb_pkg::W_CURSOR) ? r_key : ram_rdata;
    end

    leb_ram #(
        .WIDTH (leb_pkg::CHAR_W),
        .DEPTH (leb_pkg::BUF_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (leb_pkg::t_addr'(n_ptr)),
        .o_rdata (ram_rdata)
    );

    // Result register.
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_char       = '0;
        n_out_cursor = n_cursor;
        n_out_len    = n_len;
        n_last       = 1'b1;
        case (i_cmd.kind)
            leb_pkg::K_EMPTY:   n_status = leb_pkg::ST_CHAR;
            leb_pkg::K_CHAR: begin
                n_status     = leb_pkg::ST_CHAR;
                n_char       = ram_rdata;
                n_out_cursor = '0;
                n_out_len    = '0;
                n_last       = (r_ptr == len_m1);
            end
            leb_pkg::K_BREAK:   n_status = leb_pkg::ST_BREAK;
            leb_pkg::K_TIMEOUT: n_status = leb_pkg::ST_TIMEOUT;
            default:            n_status = leb_pkg::ST_HANDLED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status     <= n_status;
            r_char       <= n_char;
            r_out_cursor <= n_out_cursor;
            r_out_len    <= n_out_len;
            r_last       <= n_last;
        end
    end

    assign o_sts.cls           = cls;
    assign o_sts.cur_zero      = (r_cursor == '0);
    assign o_sts.cur_at_end    = (r_cursor == r_len);
    assign o_sts.ptr_at_cursor = (r_ptr == r_cursor);
    assign o_sts.ptr_last      = (r_ptr == len_m1);
    assign o_sts.len_zero      = (r_len == '0);
    assign o_sts.has_room      = (r_len < leb_pkg::capacity(r_max_size));
    assign o_sts.out_free      = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_char_out    = r_char;
    assign o_cursor_pos  = r_out_cursor;
    assign o_line_length = r_out_len;
    assign o_last        = r_last;

    `LEB_ASSERT(a_len_bound, r_len <= leb_pkg::t_pos'(leb_pkg::MAX_LINE), "line longer than store")
    `LEB_ASSERT(a_cursor_in_line, r_cursor <= r_len, "cursor beyond line end")
    `LEB_ASSERT(a_load_when_free, i_cmd.out_load |-> (!r_out_valid || i_out_ready), "result overwritten")
    `LEB_ASSERT(a_shift_up_in_line, (i_cmd.wr_en && i_cmd.wr_sel == leb_pkg::W_UP) |-> (r_ptr < r_len), "shift past line end")
    `LEB_ASSERT(a_shift_down_in_line, (i_cmd.wr_en && i_cmd.wr_sel == leb_pkg::W_DOWN) |-> (r_ptr != '0 && r_ptr < r_len), "shift below start")
    `LEB_ASSERT_NEXT(a_clear_all, i_cmd.edit == leb_pkg::E_CLEAR, r_len == '0 && r_cursor == '0 && r_tick == '0, "session end left state")

endmodule

/* design/line_edit_buffer.sv */
// Top level of the line edit buffer: controller, datapath and ports.
//
// The block edits one text line from a stream of input words. Each input word is either
// a keystroke (i_mode low, code on i_key) or a timer tick (i_mode high). Both the input and
// the output channel use a valid/ready handshake; a word moves when valid and ready are high.
// Settings are written through i_cfg_we, i_cfg_index and i_cfg_data; the user must do so
// only while the block is idle, which the block does not enforce. Every keystroke gives one
// output word with status 0, 2 (break) or a run of status 1 words carrying the line on enter
// or return, the final one with o_last set. A tick gives either no word or a single timeout
// word with status 3. An input word is taken in the idle state and decoded in the next
// cycle. Insertion and deletion then move the tail of the line, the characters after the
// cursor, through the store one entry per cycle. A result other than the line then waits
// in the reply step until the result register is free; the line is sent one character at
// a time as that register frees. A tick with no result goes back to idle after decoding.
// The output register parts the two sides: the block takes the next word while a result
// waits. When the receiver stalls, the block holds in its reply or line-sending step until
// the result register is free; nothing is lost or repeated.
// Reset (synchronous, active low) empties the line, clears the cursor and tick count, and
// loads the default settings. The character store itself needs no clearing, since only
// positions inside the current line are ever read.
module line_edit_buffer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_mode,
    input  logic [7:0]                 i_key,
    input  logic                       i_cfg_we,
    input  logic [leb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [leb_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic [7:0]                 o_char_out,
    output logic [5:0]                 o_cursor_pos,
    output logic [5:0]                 o_line_length,
    output logic                       o_last
);

    // Commands from the controller and status back from the datapath.
    leb_pkg::t_cmd w_cmd;
    leb_pkg::t_sts w_sts;

    leb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the settings, the line state, the store and the result register.
    leb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_char_out    (o_char_out),
        .o_cursor_pos  (o_cursor_pos),
        .o_line_length (o_line_length),
        .o_last        (o_last)
    );

endmodule

/* sim/line_edit_buffer_tb.sv */
// Self-checking testbench for the line edit buffer: directed table, random sessions, scoreboard.
//
// The testbench drives keystroke and tick words into the block and checks every result word
// against a behavioral copy of the editor kept here. That copy tracks the line store, the
// cursor, the length, the tick counter and all five settings. It is updated at the same
// clock edges at which the block takes an input word or a setting write. Each result word
// is compared field by field with the oldest expected word.
//
// Stimulus comes in two parts. The first is a short directed table. It covers the empty
// line on enter and return, edge moves, erase at the start and key zero. It also covers
// insertion in the middle, a line dump, break, a timeout and a full line. Rows whose result
// is obvious carry it typed in. Every other row is checked against the behavioral copy.
// The second part is a list of random phases, each with its own settings. The phases include
// colliding key codes, capacity zero, sizes beyond the store depth and the timeout extremes.
//
// Inputs change on the falling clock edge and outputs are sampled on the rising edge. Both
// sides idle in random bursts, except in the final phase, which runs at full rate.
module line_edit_buffer_tb;
    import leb_pkg::*;

    localparam logic  MODE_KEY    = 1'b0;
    localparam t_char DEF_LEFT    = 8'd28;
    localparam t_char DEF_RIGHT   = 8'd29;
    localparam t_char DEF_BREAK   = 8'd3;
    // Index 7 is not a register; a write to it must change nothing.
    localparam t_cfg_idx CFG_UNUSED = 3'd7;
    // Cycles allowed for the block to finish a word that gives no result (a tick).
    localparam int SETTLE_CYCLES = 80;
    localparam int DIR_ROWS      = 28;
    localparam int N_PHASES      = 7;

    typedef struct packed {
        t_status status;
        t_char   ch;
        t_pos    cur;
        t_pos    len;
        logic    last;
    } edit_result_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

    // One directed step: either an input word or a setting write. Typed rows carry
    // their single expected result; the last flag is always set on those.
    typedef struct packed {
        row_kind_e kind;
        logic      mode;
        t_char     key;
        t_cfg_idx  idx;
        logic [15:0] data;
        logic      typed;
        t_status   st;
        t_char     ch;
        t_pos      cur;
        t_pos      len;
    } dir_row_t;

    typedef struct {
        t_max_size max_size;
        t_tick     timeout;
        t_char     left;
        t_char     right;
        t_char     brk;
        int        n_items;
        bit        fill;
    } phase_t;

    // Block ports.
    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    logic  i_mode = MODE_KEY;
    t_char i_key = '0;
    logic  i_cfg_we = 1'b0;
    t_cfg_idx i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    logic [1:0] o_status;
    logic [7:0] o_char_out;
    logic [5:0] o_cursor_pos;
    logic [5:0] o_line_length;
    logic  o_last;

    // Typed expectation that travels with the word currently offered.
    logic         word_typed = 1'b0;
    edit_result_t word_exp = '0;

    // Behavioral copy of the editor.
    t_char ed_store [BUF_DEPTH];
    int    ed_cursor;
    int    ed_len;
    int    ed_ticks;
    t_max_size cfg_max_size;
    t_tick cfg_timeout;
    t_char cfg_left;
    t_char cfg_right;
    t_char cfg_break;

    edit_result_t pending_results [$];
    int  err_count = 0;
    bit  quiet = 1'b0;

    dir_row_t dir_rows [DIR_ROWS];
    phase_t   phases [N_PHASES];

    int  out_burst;
    bit  out_stall;
    logic  rnd_mode;
    t_char rnd_key;

    line_edit_buffer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_char_out    (o_char_out),
        .o_cursor_pos  (o_cursor_pos),
        .o_line_length (o_line_length),
        .o_last        (o_last)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Behavioral editor
    // ------------------------------------------------------------------

    function automatic void model_reset();
        for (int i = 0; i < BUF_DEPTH; i++) begin
            ed_store[i] = '0;
        end
        ed_cursor    = 0;
        ed_len       = 0;
        ed_ticks     = 0;
        cfg_max_size = 7'd64;
        cfg_timeout  = '0;
        cfg_left     = DEF_LEFT;
        cfg_right    = DEF_RIGHT;
        cfg_break    = DEF_BREAK;
    endfunction

    function automatic void model_config(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        case (idx)
            CFG_MAX_SIZE:  cfg_max_size = data[6:0];
            CFG_TIMEOUT:   cfg_timeout  = data[15:0];
            CFG_KEY_LEFT:  cfg_left     = data[7:0];
            CFG_KEY_RIGHT: cfg_right    = data[7:0];
            CFG_KEY_BREAK: cfg_break    = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic void push_result(input t_status st, input t_char ch, input logic lst);
        edit_result_t r;
        r.status = st;
        r.ch     = ch;
        r.cur    = t_pos'(ed_cursor);
        r.len    = t_pos'(ed_len);
        r.last   = lst;
        pending_results.push_back(r);
    endfunction

    // Applies one accepted word and queues the result words it causes.
    function automatic void edit_model_step(input logic mode, input t_char key);
        int    room;
        int    n;
        t_char dump [MAX_LINE];
        if (mode == MODE_TICK) begin
            if (cfg_timeout == '0) begin
                return;
            end
            if (ed_ticks < 65535) begin
                ed_ticks++;
            end
            if (ed_ticks >= int'(cfg_timeout)) begin
                ed_cursor = 0;
                ed_len    = 0;
                ed_ticks  = 0;
                push_result(ST_TIMEOUT, '0, 1'b1);
            end
            return;
        end
        // Enter and return win over every configurable code.
        if (key == KEY_LF || key == KEY_CR) begin
            n = ed_len;
            for (int i = 0; i < n; i++) begin
                dump[i] = ed_store[i];
            end
            ed_cursor = 0;
            ed_len    = 0;
            ed_ticks  = 0;
            if (n == 0) begin
                push_result(ST_CHAR, '0, 1'b1);
            end else begin
                for (int i = 0; i < n; i++) begin
                    push_result(ST_CHAR, dump[i], i == n - 1);
                end
            end
            return;
        end
        if (key == cfg_break) begin
            ed_cursor = 0;
            ed_len    = 0;
            ed_ticks  = 0;
            push_result(ST_BREAK, '0, 1'b1);
            return;
        end
        if (key == cfg_left) begin
            if (ed_cursor > 0) begin
                ed_cursor--;
            end
        end else if (key == cfg_right) begin
            if (ed_cursor < ed_len) begin
                ed_cursor++;
            end
        end else if (key == KEY_BS || key == KEY_DEL) begin
            if (ed_cursor > 0) begin
                for (int i = ed_cursor; i < ed_len; i++) begin
                    ed_store[i-1] = ed_store[i];
                end
                ed_cursor--;
                ed_len--;
            end
        end else begin
            // The line holds at most min(max_size, depth) minus two characters.
            room = (int'(cfg_max_size) < BUF_DEPTH) ? int'(cfg_max_size) : BUF_DEPTH;
            room = (room < 2) ? 0 : room - 2;
            if (room > MAX_LINE) begin
                room = MAX_LINE;
            end
            if (ed_len < room) begin
                for (int i = ed_len; i > ed_cursor; i--) begin
                    ed_store[i] = ed_store[i-1];
                end
                ed_store[ed_cursor] = key;
                ed_cursor++;
                ed_len++;
            end
        end
        push_result(ST_HANDLED, '0, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: results first, then setting writes, then accepted words,
    // all seen at the same rising edge the block sees them.
    // ------------------------------------------------------------------

    task automatic note_failure(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge i_clk) begin
        edit_result_t e;
        if (!i_rst_n) begin
            model_reset();
            pending_results.delete();
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("unexpected result: st=%0d ch=%0d cur=%0d len=%0d last=%0d",
                        o_status, o_char_out, o_cursor_pos, o_line_length, o_last));
                end else begin
                    e = pending_results.pop_front();
                    if (o_status !== e.status || o_char_out !== e.ch ||
                        o_cursor_pos !== e.cur || o_line_length !== e.len ||
                        o_last !== e.last) begin
                        note_failure($sformatf(
                            "mismatch: exp st=%0d ch=%0d cur=%0d len=%0d last=%0d, got st=%0d ch=%0d cur=%0d len=%0d last=%0d",
                            e.status, e.ch, e.cur, e.len, e.last,
                            o_status, o_char_out, o_cursor_pos, o_line_length, o_last));
                    end
                end
            end
            if (i_cfg_we) begin
                model_config(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                edit_model_step(i_mode, i_key);
                // A typed row replaces the single predicted word with its own.
                if (word_typed) begin
                    void'(pending_results.pop_back());
                    pending_results.push_back(word_exp);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready comes in random runs and stalls.
    // ------------------------------------------------------------------

    always begin
        @(negedge i_clk);
        if (quiet) begin
            i_out_ready <= 1'b1;
        end else begin
            out_burst = $urandom_range(1, 18);
            out_stall = ($urandom_range(0, 2) == 0);
            i_out_ready <= !out_stall;
            repeat (out_burst - 1) @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------

    // Offers one word and returns at the rising edge that accepts it. Here valid is only
    // lowered when a gap is taken, so back-to-back words keep it high.
    task automatic send_word(input logic mode, input t_char key, input logic typed,
                             input edit_result_t texp);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_key      <= key;
        word_typed <= typed;
        word_exp   <= texp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Holds the input side until every expected word has arrived.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Setting writes happen only with the block idle: nothing expected and the
    // last word given time to finish, even if it gives no result.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Picks one random word. Fill phases lean on insertion so that long and full
    // lines are reached; the rest mixes edits, dumps, breaks, ticks and noise.
    task automatic pick_word(input phase_t ph, output logic mode, output t_char key);
        int pick;
        int t_tick_w, t_ins, t_left, t_right, t_erase, t_enter, t_brk;
        pick = $urandom_range(0, 99);
        if (ph.fill) begin
            t_tick_w = 5;  t_ins = 80; t_left = 85; t_right = 90;
            t_erase = 95; t_enter = 98; t_brk = 99;
        end else begin
            t_tick_w = 10; t_ins = 55; t_left = 65; t_right = 75;
            t_erase = 85; t_enter = 93; t_brk = 97;
        end
        mode = MODE_KEY;
        key  = t_char'($urandom_range(0, 255));
        if (pick < t_tick_w) begin
            mode = MODE_TICK;
        end else if (pick < t_ins) begin
            // Random character; it may collide with a control code, which is fine.
        end else if (pick < t_left) begin
            key = ph.left;
        end else if (pick < t_right) begin
            key = ph.right;
        end else if (pick < t_erase) begin
            key = ($urandom_range(0, 1) == 0) ? KEY_BS : KEY_DEL;
        end else if (pick < t_enter) begin
            key = ($urandom_range(0, 1) == 0) ? KEY_CR : KEY_LF;
        end else if (pick < t_brk) begin
            key = ph.brk;
        end else begin
            mode = logic'($urandom_range(0, 1));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        edit_result_t texp;
        phase_t ph;

        // Directed table. Columns: kind, mode, key, register, data, typed, status,
        // character, cursor, length. Defaults are in force at the top.
        dir_rows = '{
            // Enter and return on an empty line give one empty line word.
            '{ROW_WORD, MODE_KEY, KEY_CR, CFG_MAX_SIZE, 16'd0, 1'b1, ST_CHAR, 8'd0, 6'd0, 6'd0},
            '{ROW_WORD, MODE_KEY, KEY_LF, CFG_MAX_SIZE, 16'd0, 1'b1, ST_CHAR, 8'd0, 6'd0, 6'd0},
            // Moves and erases at the start of an empty line change nothing.
            '{ROW_WORD, MODE_KEY, DEF_LEFT, CFG_MAX_SIZE, 16'd0, 1'b1, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            '{ROW_WORD, MODE_KEY, DEF_RIGHT, CFG_MAX_SIZE, 16'd0, 1'b1, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            '{ROW_WORD, MODE_KEY, KEY_BS, CFG_MAX_SIZE, 16'd0, 1'b1, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            '{ROW_WORD, MODE_KEY, KEY_DEL, CFG_MAX_SIZE, 16'd0, 1'b1, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            // A tick with the timeout disabled gives nothing.
            '{ROW_WORD, MODE_TICK, 8'd0, CFG_MAX_SIZE, 16'd0, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            // Key zero and key 255 are ordinary characters.
            '{ROW_WORD, MODE_KEY, 8'd0, CFG_MAX_SIZE, 16'd0, 1'b1, ST_HANDLED, 8'd0, 6'd1, 6'd1},
            '{ROW_WORD, MODE_KEY, 8'd255, CFG_MAX_SIZE, 16'd0, 1'b1, ST_HANDLED, 8'd0, 6'd2, 6'd2},
            '{ROW_WORD, MODE_KEY, 8'd97, CFG_MAX_SIZE, 16'd0, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            '{ROW_WORD, MODE_KEY, DEF_LEFT, CFG_MAX_SIZE, 16'd0, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            '{ROW_WORD, MODE_KEY, DEF_LEFT, CFG_MAX_SIZE, 16'd0, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            // Insert and erase in the middle of the line shift the tail.
            '{ROW_WORD, MODE_KEY, 8'd98, CFG_MAX_SIZE, 16'd0, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            '{ROW_WORD, MODE_KEY, KEY_DEL, CFG_MAX_SIZE, 16'd0, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            '{ROW_WORD, MODE_KEY, DEF_RIGHT, CFG_MAX_SIZE, 16'd0, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            '{ROW_WORD, MODE_KEY, DEF_RIGHT, CFG_MAX_SIZE, 16'd0, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            '{ROW_WORD, MODE_KEY, DEF_RIGHT, CFG_MAX_SIZE, 16'd0, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            '{ROW_WORD, MODE_KEY, KEY_CR, CFG_MAX_SIZE, 16'd0, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            '{ROW_WORD, MODE_KEY, 8'd120, CFG_MAX_SIZE, 16'd0, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            // Break ends the session and clears the line.
            '{ROW_WORD, MODE_KEY, DEF_BREAK, CFG_MAX_SIZE, 16'd0, 1'b1, ST_BREAK, 8'd0, 6'd0, 6'd0},
            // Two ticks to a timeout.
            '{ROW_CFG, MODE_KEY, 8'd0, CFG_TIMEOUT, 16'd2, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            '{ROW_WORD, MODE_TICK, 8'd0, CFG_MAX_SIZE, 16'd0, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            '{ROW_WORD, MODE_TICK, 8'd255, CFG_MAX_SIZE, 16'd0, 1'b1, ST_TIMEOUT, 8'd0, 6'd0, 6'd0},
            // A one-character line: the second insertion finds it full.
            '{ROW_CFG, MODE_KEY, 8'd0, CFG_MAX_SIZE, 16'd3, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            '{ROW_WORD, MODE_KEY, 8'd65, CFG_MAX_SIZE, 16'd0, 1'b1, ST_HANDLED, 8'd0, 6'd1, 6'd1},
            '{ROW_WORD, MODE_KEY, 8'd66, CFG_MAX_SIZE, 16'd0, 1'b1, ST_HANDLED, 8'd0, 6'd1, 6'd1},
            '{ROW_WORD, MODE_KEY, KEY_LF, CFG_MAX_SIZE, 16'd0, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0},
            // A write to an index that holds no register.
            '{ROW_CFG, MODE_KEY, 8'd0, CFG_UNUSED, 16'hFFFF, 1'b0, ST_HANDLED, 8'd0, 6'd0, 6'd0}
        };

        // Random phases. They walk the size from beyond the store depth down to zero,
        // the timeout from off through one to its maximum, and several code collisions:
        // left on return, right on backspace, break on left, left and right on delete.
        // A long count under the maximum timeout followed by a small one makes the
        // next tick time out at once.
        phases[0] = '{7'd64,  16'd0,     DEF_LEFT, DEF_RIGHT, DEF_BREAK, 40, 1'b0};
        phases[1] = '{7'd127, 16'd65535, 8'd0,     8'd255,    8'd27,     80, 1'b1};
        phases[2] = '{7'd6,   16'd3,     KEY_CR,   KEY_BS,    DEF_LEFT,  50, 1'b0};
        phases[3] = '{7'd0,   16'd1,     8'd255,   8'd0,      8'd255,    25, 1'b0};
        phases[4] = '{7'd1,   16'd2,     KEY_DEL,  KEY_DEL,   KEY_LF,    25, 1'b0};
        phases[5] = '{7'd2,   16'd65535, DEF_LEFT, DEF_RIGHT, DEF_BREAK, 20, 1'b0};
        phases[6] = '{7'd64,  16'd7,     DEF_LEFT, DEF_RIGHT, DEF_BREAK, 70, 1'b1};

        // Reset is held from the start and released on a falling edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                texp = '{dir_rows[r].st, dir_rows[r].ch, dir_rows[r].cur, dir_rows[r].len, 1'b1};
                send_word(dir_rows[r].mode, dir_rows[r].key, dir_rows[r].typed, texp);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            ph = phases[p];
            write_reg(CFG_MAX_SIZE,  CFG_W'(ph.max_size));
            write_reg(CFG_TIMEOUT,   CFG_W'(ph.timeout));
            write_reg(CFG_KEY_LEFT,  CFG_W'(ph.left));
            write_reg(CFG_KEY_RIGHT, CFG_W'(ph.right));
            write_reg(CFG_KEY_BREAK, CFG_W'(ph.brk));
            // The last phase runs with neither side idling.
            quiet = (p == N_PHASES - 1);
            for (int i = 0; i < ph.n_items; i++) begin
                // Now and then, and once for certain, the sender waits for the
                // receiver to catch up completely.
                if (!quiet && ((p == 0 && i == 20) || $urandom_range(0, 39) == 0)) begin
                    drain_results();
                end
                pick_word(ph, rnd_mode, rnd_key);
                send_word(rnd_mode, rnd_key, 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            note_failure($sformatf("%0d expected results never arrived", pending_results.size()));
        end
        if (err_count == 0) begin
            $display("line_edit_buffer_tb: done, clean");
        end else begin
            $display("line_edit_buffer_tb: done, errors");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("line_edit_buffer_tb: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/leb_pkg.sv
design/leb_ram.sv
design/leb_ctrl.sv
design/leb_dp.sv
design/line_edit_buffer.sv
sim/line_edit_buffer_tb.sv
